FILE: rtl/core/probe_request_ssid_collector_assert.svh
// assertion macros shared by the collector rtl
// no dependencies; include by bare file name
`ifndef PROBE_REQUEST_SSID_COLLECTOR_ASSERT_SVH
`define PROBE_REQUEST_SSID_COLLECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PRSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/prsc_pkg.sv
// types and constants for the probe request ssid collector
// no dependencies
`timescale 1ns / 1ps

package prsc_pkg;

  localparam int unsigned SSID_MAX_BYTES = 32;
  localparam int unsigned SSID_LEN_W     = 6;

  localparam logic [7:0] PROBE_REQ_BYTE = 8'h40;
  localparam logic [7:0] SSID_TAG       = 8'h00;
  localparam logic [7:0] PRINT_LOW      = 8'd32;
  localparam logic [7:0] PRINT_HIGH     = 8'd126;
  localparam logic [6:0] MIN_FRAME_LEN  = 7'd28;

  localparam logic [5:0] TAG_ID_POS   = 6'd24;
  localparam logic [5:0] TAG_LEN_POS  = 6'd25;
  localparam logic [5:0] SSID_POS     = 6'd26;
  localparam logic [5:0] SSID_POS_END = 6'(26 + SSID_MAX_BYTES);
  localparam logic [5:0] POS_MAX      = 6'd63;

  typedef logic [SSID_MAX_BYTES-1:0][7:0] ssid_t;

  typedef enum logic [2:0] {
    VD_NOT_PROBE = 3'd0,
    VD_BAD_TAG   = 3'd1,
    VD_DUPLICATE = 3'd2,
    VD_ADDED     = 3'd3,
    VD_FULL      = 3'd4
  } verdict_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  // frame check outcome, valid on the byte that ends the frame
  typedef struct packed {
    logic                  probe_ok;
    logic                  tag_ok;
    logic [SSID_LEN_W-1:0] ssid_len;
  } judge_t;

  // one table entry: length and bytes
  typedef struct packed {
    logic [SSID_LEN_W-1:0] len;
    ssid_t                 ssid;
  } entry_t;

endpackage

FILE: rtl/core/prsc_frame_parser.sv
// per-frame byte parser: header, ssid tag, ssid bytes and printable check
// depends on prsc_pkg
`timescale 1ns / 1ps

module prsc_frame_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_acc_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                is_management_i,
  input  logic                frame_end_i,
  output prsc_pkg::judge_t    judge_o,
  output prsc_pkg::ssid_t     ssid_o
);

  logic [5:0]            pos_q, pos_d;
  logic [7:0]            hdr_q, hdr_d;
  logic [7:0]            tag_id_q, tag_id_d;
  logic [7:0]            tag_len_q, tag_len_d;
  logic                  np_q, np_d;
  logic                  mgmt_q, mgmt_d;
  prsc_pkg::ssid_t       ssid_q;

  logic                  in_ssid;
  logic [5:0]            ssid_off;
  logic [4:0]            ssid_k;
  logic                  printable;
  logic [6:0]            len;
  logic [8:0]            ssid_end;

  // where the current byte lands
  assign in_ssid   = (pos_q >= prsc_pkg::SSID_POS) && (pos_q < prsc_pkg::SSID_POS_END);
  assign ssid_off  = pos_q - prsc_pkg::SSID_POS;
  assign ssid_k    = ssid_off[4:0];
  assign printable = (frame_byte_i >= prsc_pkg::PRINT_LOW) &&
                     (frame_byte_i <= prsc_pkg::PRINT_HIGH);
  assign len       = {1'b0, pos_q} + 7'd1;

  // field values including the current byte
  always_comb begin
    hdr_d     = hdr_q;
    mgmt_d    = mgmt_q;
    tag_id_d  = tag_id_q;
    tag_len_d = tag_len_q;
    np_d      = np_q;
    if (pos_q == 6'd0) begin
      hdr_d  = frame_byte_i;
      mgmt_d = is_management_i;
    end else if (pos_q == prsc_pkg::TAG_ID_POS) begin
      tag_id_d = frame_byte_i;
    end else if (pos_q == prsc_pkg::TAG_LEN_POS) begin
      tag_len_d = frame_byte_i;
    end else if (in_ssid && ({3'b000, ssid_k} < tag_len_q) && !printable) begin
      np_d = 1'b1;
    end
    pos_d = (pos_q < prsc_pkg::POS_MAX) ? pos_q + 6'd1 : pos_q;
  end

  // frame verdict inputs for the byte that ends the frame
  assign ssid_end = 9'd26 + {1'b0, tag_len_d};

  always_comb begin
    judge_o.probe_ok = mgmt_d && (len >= prsc_pkg::MIN_FRAME_LEN) &&
                       (hdr_d == prsc_pkg::PROBE_REQ_BYTE);
    judge_o.tag_ok   = (tag_id_d == prsc_pkg::SSID_TAG) && (tag_len_d != 8'd0) &&
                       (tag_len_d <= 8'(prsc_pkg::SSID_MAX_BYTES)) &&
                       (ssid_end <= {2'b00, len}) && !np_d;
    judge_o.ssid_len = tag_len_d[5:0];
  end

  // per-frame control state, cleared after each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_q     <= '0;
      tag_id_q  <= '0;
      tag_len_q <= '0;
      np_q      <= 1'b0;
      mgmt_q    <= 1'b0;
    end else if (byte_acc_i) begin
      if (frame_end_i) begin
        pos_q     <= '0;
        hdr_q     <= '0;
        tag_id_q  <= '0;
        tag_len_q <= '0;
        np_q      <= 1'b0;
        mgmt_q    <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        hdr_q     <= hdr_d;
        tag_id_q  <= tag_id_d;
        tag_len_q <= tag_len_d;
        np_q      <= np_d;
        mgmt_q    <= mgmt_d;
      end
    end
  end

  // ssid bytes; only bytes below the tag length are ever compared
  always_ff @(posedge clk_i) begin
    if (byte_acc_i && in_ssid) begin
      ssid_q[ssid_k] <= frame_byte_i;
    end
  end

  assign ssid_o = ssid_q;

endmodule

FILE: rtl/core/probe_request_ssid_collector.sv
// Results: one result per frame, given the cycle after the final byte for a
// non-probe or bad tag; a valid probe scans the table one entry per cycle
// through the memory read port, giving a result once the matching entry has
// been compared, or once every stored entry has been compared when appended or full.
// Throughput: one byte per cycle; input stalls during the table scan and on a frame end while a result waits.
// Reset: clears entry count, probe count and frame state; table stays unset.
`timescale 1ns / 1ps

module probe_request_ssid_collector #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_management_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [5:0]  entry_slot_o,
  output logic [6:0]  entry_total_o,
  output logic [31:0] probe_total_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  `include "probe_request_ssid_collector_assert.svh"

  prsc_pkg::state_e   state_q, state_d;
  prsc_pkg::verdict_e verdict_q, verdict_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic               out_valid_q, out_valid_d;
  logic [CntW-1:0]    stored_q, stored_d;
  logic [31:0]        probe_cnt_q, probe_cnt_d;
  logic [CntW-1:0]    rd_cnt_q, rd_cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [prsc_pkg::SSID_LEN_W-1:0] srch_len_q, srch_len_d;

  logic               byte_acc;
  prsc_pkg::judge_t   judge;
  prsc_pkg::ssid_t    ssid;

  prsc_pkg::entry_t   mem_q [TABLE_DEPTH];
  prsc_pkg::entry_t   rdata_q;
  prsc_pkg::entry_t   wdata;
  logic               mem_we;
  logic               issue;
  logic [IdxW-1:0]    rd_idx;
  logic [IdxW-1:0]    wr_idx;
  logic [prsc_pkg::SSID_MAX_BYTES-1:0] byte_ok;
  logic               hit;
  logic               full;
  logic [IdxW+5:0]    slot_ext;
  logic [CntW+6:0]    total_ext;

  // input handshake: hold off during a scan, or a frame end while a result waits
  assign in_stall_o = (state_q != prsc_pkg::ST_IDLE) || (out_valid_q && frame_end_i);
  assign byte_acc   = in_valid_i && !in_stall_o;

  prsc_frame_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_acc_i      (byte_acc),
    .frame_byte_i    (frame_byte_i),
    .is_management_i (is_management_i),
    .frame_end_i     (frame_end_i),
    .judge_o         (judge),
    .ssid_o          (ssid)
  );

  // compare the entry read last cycle against the frame ssid
  always_comb begin
    for (int k = 0; k < prsc_pkg::SSID_MAX_BYTES; k++) begin
      byte_ok[k] = (6'(k) >= srch_len_q) || (rdata_q.ssid[k] == ssid[k]);
    end
  end

  assign hit    = cmp_vld_q && (rdata_q.len == srch_len_q) && (&byte_ok);
  assign full   = (stored_q == CntW'(TABLE_DEPTH));
  assign rd_idx = rd_cnt_q[IdxW-1:0];
  assign wr_idx = stored_q[IdxW-1:0];
  assign issue  = (state_q == prsc_pkg::ST_SEARCH) && !hit && (rd_cnt_q < stored_q);
  assign wdata  = '{len: srch_len_q, ssid: ssid};

  // next state and result
  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    stored_d    = stored_q;
    probe_cnt_d = probe_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    srch_len_d  = srch_len_q;
    mem_we      = 1'b0;
    unique case (state_q)
      prsc_pkg::ST_IDLE: begin
        if (byte_acc && frame_end_i) begin
          if (!judge.probe_ok) begin
            verdict_d   = prsc_pkg::VD_NOT_PROBE;
            slot_d      = '0;
            out_valid_d = 1'b1;
          end else if (!judge.tag_ok) begin
            verdict_d   = prsc_pkg::VD_BAD_TAG;
            slot_d      = '0;
            out_valid_d = 1'b1;
          end else begin
            probe_cnt_d = probe_cnt_q + 32'd1;
            srch_len_d  = judge.ssid_len;
            rd_cnt_d    = '0;
            state_d     = prsc_pkg::ST_SEARCH;
          end
        end
      end
      prsc_pkg::ST_SEARCH: begin
        if (hit) begin
          verdict_d   = prsc_pkg::VD_DUPLICATE;
          slot_d      = cmp_idx_q;
          out_valid_d = 1'b1;
          state_d     = prsc_pkg::ST_IDLE;
        end else if (issue) begin
          rd_cnt_d  = rd_cnt_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx;
        end else if (!cmp_vld_q) begin
          // scan done without a match
          if (full) begin
            verdict_d = prsc_pkg::VD_FULL;
            slot_d    = '0;
          end else begin
            verdict_d = prsc_pkg::VD_ADDED;
            slot_d    = wr_idx;
            mem_we    = 1'b1;
            stored_d  = stored_q + CntW'(1);
          end
          out_valid_d = 1'b1;
          state_d     = prsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prsc_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prsc_pkg::ST_IDLE;
      verdict_q   <= prsc_pkg::VD_NOT_PROBE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      stored_q    <= '0;
      probe_cnt_q <= '0;
      rd_cnt_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      srch_len_q  <= '0;
    end else begin
      state_q     <= state_d;
      verdict_q   <= verdict_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      stored_q    <= stored_d;
      probe_cnt_q <= probe_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      srch_len_q  <= srch_len_d;
    end
  end

  // ssid table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  // result outputs; counters hold while a result waits
  assign slot_ext      = {6'b000000, slot_q};
  assign total_ext     = {7'b0000000, stored_q};
  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign entry_slot_o  = slot_ext[5:0];
  assign entry_total_o = total_ext[6:0];
  assign probe_total_o = probe_cnt_q;

  // checks
  `PRSC_ASSERT_IMPL(a_stored_bound, clk_i, rst_ni, 1'b1, stored_q <= CntW'(TABLE_DEPTH),
    "entry count above table depth")
  `PRSC_ASSERT_IMPL(a_write_room, clk_i, rst_ni, mem_we, !full && !out_valid_q,
    "table write when full or with a result pending")
  `PRSC_ASSERT_NEXT(a_write_count, clk_i, rst_ni, mem_we,
    stored_q == $past(stored_q) + CntW'(1), "entry count not advanced on write")
  `PRSC_ASSERT_IMPL(a_scan_stall, clk_i, rst_ni, state_q == prsc_pkg::ST_SEARCH,
    in_stall_o && !out_valid_q, "input taken or result pending during scan")

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the probe request ssid collector
// needs prsc_pkg and probe_request_ssid_collector; frames are predicted byte by byte
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    prsc_pkg::verdict_e verdict;
    logic [5:0]         slot;
    logic [6:0]         total;
    logic [31:0]        probes;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = '0;
  logic        is_management_i = 1'b0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [5:0]  entry_slot_o;
  logic [6:0]  entry_total_o;
  logic [31:0] probe_total_o;

  // table of collected names as the bench sees it
  prsc_pkg::ssid_t known_names [TABLE_DEPTH];
  logic [5:0]      known_lens  [TABLE_DEPTH];
  int unsigned     known_count = 0;
  logic [31:0]     probe_count = '0;

  // state of the frame being received
  logic [5:0]      rx_pos = '0;
  logic [7:0]      rx_subtype = '0;
  logic [7:0]      rx_tag = '0;
  logic [7:0]      rx_len = '0;
  prsc_pkg::ssid_t rx_name = '0;
  logic            rx_bad_char = 1'b0;
  logic            rx_mgmt = 1'b0;

  frame_result_t awaited_results [$];
  logic [7:0]    frame_buf [$];
  logic          frame_mgmt;

  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned verdict_tally [5] = '{default: 0};
  frame_result_t want;

  probe_request_ssid_collector #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .is_management_i(is_management_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .entry_slot_o   (entry_slot_o),
    .entry_total_o  (entry_total_o),
    .probe_total_o  (probe_total_o)
  );

  always #5 clk_i = ~clk_i;

  // track one accepted byte; at frame end judge the frame and queue its result
  function automatic void absorb_byte(logic [7:0] b, logic mgmt, logic last);
    int unsigned     k;
    int unsigned     flen;
    bit              hit;
    prsc_pkg::ssid_t trimmed;
    frame_result_t   r;
    if (rx_pos == 0) begin
      rx_subtype = b;
      rx_mgmt    = mgmt;
    end else if (rx_pos == prsc_pkg::TAG_ID_POS) begin
      rx_tag = b;
    end else if (rx_pos == prsc_pkg::TAG_LEN_POS) begin
      rx_len = b;
    end else if (rx_pos >= prsc_pkg::SSID_POS && rx_pos < prsc_pkg::SSID_POS_END) begin
      k = rx_pos - prsc_pkg::SSID_POS;
      rx_name[k] = b;
      if (k < rx_len && (b < prsc_pkg::PRINT_LOW || b > prsc_pkg::PRINT_HIGH))
        rx_bad_char = 1'b1;
    end
    flen = int'(rx_pos) + 1;
    if (rx_pos < prsc_pkg::POS_MAX) rx_pos++;
    if (!last) return;

    r.slot = '0;
    if (!rx_mgmt || flen < prsc_pkg::MIN_FRAME_LEN ||
        rx_subtype != prsc_pkg::PROBE_REQ_BYTE) begin
      r.verdict = prsc_pkg::VD_NOT_PROBE;
    end else if (rx_tag != prsc_pkg::SSID_TAG || rx_len == 0 ||
                 rx_len > prsc_pkg::SSID_MAX_BYTES ||
                 int'(prsc_pkg::SSID_POS) + int'(rx_len) > flen || rx_bad_char) begin
      r.verdict = prsc_pkg::VD_BAD_TAG;
    end else begin
      probe_count++;
      // names are kept with the bytes past their length cleared
      trimmed = rx_name;
      for (int i = 0; i < prsc_pkg::SSID_MAX_BYTES; i++) if (i >= rx_len) trimmed[i] = '0;
      hit = 1'b0;
      for (int i = 0; i < known_count && !hit; i++) begin
        if (known_lens[i] == rx_len && known_names[i] == trimmed) begin
          hit    = 1'b1;
          r.slot = 6'(i);
        end
      end
      if (hit) begin
        r.verdict = prsc_pkg::VD_DUPLICATE;
      end else if (known_count >= TABLE_DEPTH) begin
        r.verdict = prsc_pkg::VD_FULL;
      end else begin
        known_names[known_count] = trimmed;
        known_lens[known_count]  = rx_len[5:0];
        r.slot    = 6'(known_count);
        r.verdict = prsc_pkg::VD_ADDED;
        known_count++;
      end
    end
    r.total  = 7'(known_count);
    r.probes = probe_count;
    awaited_results.push_back(r);
    verdict_tally[r.verdict]++;

    rx_pos      = '0;
    rx_subtype  = '0;
    rx_tag      = '0;
    rx_len      = '0;
    rx_name     = '0;
    rx_bad_char = 1'b0;
    rx_mgmt     = 1'b0;
  endfunction

  // offer one byte, idling at random first, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic mgmt, input logic last);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    frame_byte_i    <= b;
    is_management_i <= mgmt;
    frame_end_i     <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    absorb_byte(b, mgmt, last);
    bytes_sent++;
  endtask

  // send the frame in frame_buf; the management flag only matters on byte 0
  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], (i == 0) ? frame_mgmt : 1'($urandom), i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // drop valid and hold off until every queued result has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // header, ssid tag and length, name bytes, then padding, cut to flen
  function automatic void build_frame(logic [7:0] subtype, logic [7:0] tag,
                                      logic [7:0] len_field, prsc_pkg::ssid_t name,
                                      int unsigned flen, logic mgmt);
    frame_buf.delete();
    frame_mgmt = mgmt;
    frame_buf.push_back(subtype);
    for (int i = 1; i < prsc_pkg::TAG_ID_POS; i++) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(tag);
    frame_buf.push_back(len_field);
    for (int i = 0; i < prsc_pkg::SSID_MAX_BYTES; i++) frame_buf.push_back(name[i]);
    while (frame_buf.size() < flen) frame_buf.push_back(8'($urandom));
    while (frame_buf.size() > flen) void'(frame_buf.pop_back());
  endfunction

  // printable name of n bytes, random bytes after it; optionally one bad byte
  function automatic prsc_pkg::ssid_t random_name(int unsigned n, bit clean);
    prsc_pkg::ssid_t s;
    for (int i = 0; i < prsc_pkg::SSID_MAX_BYTES; i++)
      s[i] = (i < n) ? 8'($urandom_range(prsc_pkg::PRINT_HIGH, prsc_pkg::PRINT_LOW)) :
                       8'($urandom);
    if (!clean)
      s[$urandom_range(n - 1)] = $urandom_range(1) ? 8'($urandom_range(31)) :
                                                     8'($urandom_range(255, 127));
    return s;
  endfunction

  // shortest legal frame for an n byte name plus some slack, now and then a long one
  function automatic int unsigned frame_len_for(int unsigned n);
    int unsigned base;
    base = (prsc_pkg::SSID_POS + n < prsc_pkg::MIN_FRAME_LEN) ? prsc_pkg::MIN_FRAME_LEN :
                                                                prsc_pkg::SSID_POS + n;
    if ($urandom_range(9) == 0) return $urandom_range(80, 64);
    return base + $urandom_range(8);
  endfunction

  // mostly well formed probes, some reusing stored names, plus broken frames and noise
  task automatic send_random_frame();
    int unsigned     roll, n, flen, idx;
    logic [7:0]      sub;
    prsc_pkg::ssid_t name;
    roll = $urandom_range(99);
    n    = $urandom_range(prsc_pkg::SSID_MAX_BYTES, 1);
    name = random_name(n, 1'b1);
    if (roll < 70 && known_count != 0 && $urandom_range(1)) begin
      idx  = $urandom_range(known_count - 1);
      name = known_names[idx];
      n    = known_lens[idx];
      // same bytes, length one off
      if (roll >= 55) begin
        if (n > 1 && $urandom_range(1)) begin
          n--;
        end else if (n < prsc_pkg::SSID_MAX_BYTES) begin
          name[n] = 8'($urandom_range(prsc_pkg::PRINT_HIGH, prsc_pkg::PRINT_LOW));
          n++;
        end
      end
    end
    flen = frame_len_for(n);
    if (roll < 70) begin
      build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), name, flen, 1'b1);
    end else if (roll < 88) begin
      case ($urandom_range(7))
        0: build_frame(prsc_pkg::PROBE_REQ_BYTE, 8'($urandom_range(255, 1)), 8'(n), name,
                       flen, 1'b1);
        1: build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd0, name, flen, 1'b1);
        2: build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG,
                       8'($urandom_range(255, 33)), name, flen, 1'b1);
        3: begin
          if (n < 3) n = 3;
          build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), name,
                      $urandom_range(prsc_pkg::SSID_POS + n - 1, prsc_pkg::MIN_FRAME_LEN),
                      1'b1);
        end
        4: build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n),
                       random_name(n, 1'b0), flen, 1'b1);
        5: build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), name, flen, 1'b0);
        6: begin
          sub = 8'($urandom);
          if (sub == prsc_pkg::PROBE_REQ_BYTE) sub = 8'h50;
          build_frame(sub, prsc_pkg::SSID_TAG, 8'(n), name, flen, 1'b1);
        end
        default: build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), name,
                             $urandom_range(prsc_pkg::MIN_FRAME_LEN - 1, 1), 1'b1);
      endcase
    end else begin
      // noise of 1 to 80 bytes
      frame_buf.delete();
      frame_mgmt = 1'($urandom);
      repeat ($urandom_range(80, 1)) frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  // every rejection reason, printable limits, duplicates and long frames
  task automatic test_directed();
    prsc_pkg::ssid_t name, bad_name, rim_name;
    name = random_name(4, 1'b1);
    for (int i = 0; i < prsc_pkg::SSID_MAX_BYTES; i++)
      rim_name[i] = (i % 2) ? prsc_pkg::PRINT_HIGH : prsc_pkg::PRINT_LOW;
    // frame ends on its first byte
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, name, 1, 1'b1);
    send_frame();
    // one byte under the minimum length
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd1, name,
                prsc_pkg::MIN_FRAME_LEN - 1, 1'b1);
    send_frame();
    // not a management frame, then another subtype
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, name, 30, 1'b0);
    send_frame();
    build_frame(8'h50, prsc_pkg::SSID_TAG, 8'd4, name, 30, 1'b1);
    send_frame();
    // wrong tag, zero length, too long, running past the frame end
    build_frame(prsc_pkg::PROBE_REQ_BYTE, 8'hdd, 8'd4, name, 30, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd0, name, 30, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd33, name, 63, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd10, random_name(10, 1'b1),
                35, 1'b1);
    send_frame();
    // control byte first, delete last
    bad_name = name;
    bad_name[0] = 8'h1f;
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, bad_name, 30, 1'b1);
    send_frame();
    bad_name = name;
    bad_name[3] = 8'h7f;
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, bad_name, 30, 1'b1);
    send_frame();
    // full 32 byte name of the printable limits, frame ends right after it
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd32, rim_name,
                prsc_pkg::SSID_POS_END, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd32, rim_name,
                prsc_pkg::SSID_POS_END, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd31, rim_name,
                prsc_pkg::SSID_POS_END, 1'b1);
    send_frame();
    // control bytes past the name are ignored, frame runs beyond offset 63
    name[4] = 8'h00;
    name[5] = 8'hff;
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, name, 80, 1'b1);
    send_frame();
    build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'd4, name,
                prsc_pkg::MIN_FRAME_LEN, 1'b1);
    send_frame();
    wait_drain();
  endtask

  // random frames until enough bytes and results have gone through
  task automatic test_random_mix(input int unsigned byte_goal, input int unsigned frame_goal);
    int unsigned first_byte, first_frame;
    first_byte  = bytes_sent;
    first_frame = frames_sent;
    while (bytes_sent - first_byte < byte_goal || frames_sent - first_frame < frame_goal)
      send_random_frame();
    wait_drain();
  endtask

  // receiver holds off for a long stretch while probes keep coming
  task automatic test_backpressure();
    int unsigned n;
    hold_request = 1'b1;
    repeat (8) begin
      n = $urandom_range(prsc_pkg::SSID_MAX_BYTES, 1);
      build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), random_name(n, 1'b1),
                  frame_len_for(n), 1'b1);
      send_frame();
    end
    wait_drain();
  endtask

  // fill every slot with new short names, then overflow, with no idling
  task automatic test_fill_table();
    int unsigned n;
    calm = 1'b1;
    while (known_count < TABLE_DEPTH) begin
      n = $urandom_range(4, 1);
      build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), random_name(n, 1'b1),
                  frame_len_for(n), 1'b1);
      send_frame();
    end
    repeat (5) begin
      n = $urandom_range(prsc_pkg::SSID_MAX_BYTES, 5);
      build_frame(prsc_pkg::PROBE_REQ_BYTE, prsc_pkg::SSID_TAG, 8'(n), random_name(n, 1'b1),
                  frame_len_for(n), 1'b1);
      send_frame();
    end
    calm = 1'b0;
    wait_drain();
  endtask

  // receiver side: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_request) begin
      out_stall_i  <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_request = 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 27);
    end
  end

  function automatic void note_mismatch(string what, logic [31:0] expected_v,
                                        logic [31:0] actual_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in result %0d, %s: expected %0d, got %0d",
               results_seen, what, expected_v, actual_v);
  endfunction

  // compare each result transaction against the oldest queued frame result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with no frame outstanding", results_seen);
      end else begin
        want = awaited_results.pop_front();
        if (verdict_o !== want.verdict) note_mismatch("verdict", want.verdict, verdict_o);
        if (entry_slot_o !== want.slot) note_mismatch("entry_slot", want.slot, entry_slot_o);
        if (entry_total_o !== want.total)
          note_mismatch("entry_total", want.total, entry_total_o);
        if (probe_total_o !== want.probes)
          note_mismatch("probe_total", want.probes, probe_total_o);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("run limit reached with %0d results outstanding", awaited_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(750, 40);
    test_backpressure();
    test_fill_table();
    test_random_mix(400, 30);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      $display("%0d frame results never arrived", awaited_results.size());
    $display("covered %0d bytes in %0d frames, %0d results checked, table at %0d of %0d",
             bytes_sent, frames_sent, results_seen, known_count, TABLE_DEPTH);
    $display("verdicts: not probe %0d, bad tag %0d, duplicate %0d, added %0d, full %0d",
             verdict_tally[prsc_pkg::VD_NOT_PROBE], verdict_tally[prsc_pkg::VD_BAD_TAG],
             verdict_tally[prsc_pkg::VD_DUPLICATE], verdict_tally[prsc_pkg::VD_ADDED],
             verdict_tally[prsc_pkg::VD_FULL]);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
